>>> src/sqe_pkg.sv
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared types and constants of the sorted quartile engine: sizes, payload
// structs, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package sqe_pkg;

	localparam int MAX_ITEMS    = 64;
	localparam int GRADE_BITS   = 8;
	localparam int CNT_W        = $clog2(MAX_ITEMS + 1);
	localparam int ACC_W        = GRADE_BITS + 1;

	localparam int GRADE_W      = 8;
	localparam int QUART_W      = 9;
	localparam int ITEM_COUNT_W = 7;

	typedef logic [GRADE_BITS-1:0] grade_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [ACC_W-1:0]      acc_t;

	typedef struct packed {
		logic [GRADE_W-1:0] grade;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic [QUART_W-1:0]      lower_quartile_x2;
		logic [QUART_W-1:0]      median_x2;
		logic [QUART_W-1:0]      upper_quartile_x2;
		logic [ITEM_COUNT_W-1:0] item_count;
		logic                    status;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_COLLECT = 4'b0001,
		ST_SETUP   = 4'b0010,
		ST_DRAIN   = 4'b0100,
		ST_DONE    = 4'b1000
	} state_t;

	typedef struct packed {
		logic accept;
		logic setup;
		logic drain;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic drain_end;
	} stat_t;

endpackage

>>> src/sorted_quartile_engine_top.sv
// ----------------------------------------------------------------------------
// sorted_quartile_engine_top
// Collects grades into a sorted set and reports Q1, median and Q3, doubled.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one grade per request, with a last
// flag that closes the set. Grades are taken at one per cycle while the
// engine collects; each is inserted in sorted order in the same cycle.
// Grades beyond MAX_ITEMS are dropped and flagged in the result status.
// Output channel: out_valid/out_ready carry one result per set.
// After the request with last is taken, the engine passes through a setup
// state, then drains the sorted chain through its head cell, one kept grade
// at a time, and then, once the output register is free, loads the result.
// During this work in_ready is low; how long a set of grades sent back to
// back occupies the engine is set by the single-cell drain of the chain.
// Each dropped grade is still taken while the engine collects.
// The result sits in an output register: the next set is collected while it
// waits, and only the completion of that next set stalls until the receiver
// takes the pending result.
// Reset (arst_n low) empties the set, clears the overflow flag and drops any
// pending result.
// ----------------------------------------------------------------------------
module sorted_quartile_engine_top
	import sqe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	cmd_t  cmd;
	stat_t stat;

	sqe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_item.last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sqe_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.stat     (stat),
		.out_item (out_item)
	);

endmodule

>>> src/sqe_ctrl.sv
// ----------------------------------------------------------------------------
// sqe_ctrl
// Controller of the sorted quartile engine: sequences collection, index
// setup, the drain of the sorted chain and the output register handshake.
// ----------------------------------------------------------------------------
module sqe_ctrl
	import sqe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  in_last,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_COLLECT);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		cmd.accept   = in_valid && (state_q == ST_COLLECT);
		case (state_q)
			ST_COLLECT: begin
				if (in_valid && in_last) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_DRAIN;
			end
			ST_DRAIN: begin
				cmd.drain = 1'b1;
				if (stat.drain_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_COLLECT;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/sqe_dp.sv
// ----------------------------------------------------------------------------
// sqe_dp
// Datapath of the sorted quartile engine: an insertion chain of compare
// cells, the fill count, the quartile index logic, three accumulators fed
// from the head of the chain while it drains, and the result register.
// ----------------------------------------------------------------------------
module sqe_dp
	import sqe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  in_item_t  in_item,
	output stat_t     stat,
	output out_item_t out_item
);

	grade_t    cell_q [MAX_ITEMS];
	logic      gt     [MAX_ITEMS];
	cnt_t      count_q;
	logic      ovf_q;
	grade_t    g;
	logic      full;

	cnt_t      k_q;
	cnt_t      a1_q, b1_q, a2_q, b2_q, a3_q, b3_q;
	acc_t      q1_q, q2_q, q3_q;
	out_item_t out_q;

	cnt_t      half, h2, lo3, a1, b1, a2, b2, a3, b3;
	acc_t      head;

	assign g    = in_item.grade[GRADE_BITS-1:0];
	assign full = (count_q == cnt_t'(MAX_ITEMS));
	assign head = {1'b0, cell_q[0]};

	// A cell at or above the fill count behaves as holding a larger grade, so
	// a new grade that is not below any kept one lands right at the count.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		assign gt[i] = (cnt_t'(i) >= count_q) || (cell_q[i] > g);

		always_ff @(posedge clk) begin
			if (cmd.accept && !full && gt[i]) begin
				if (i == 0) begin
					cell_q[i] <= g;
				end else begin
					cell_q[i] <= gt[(i > 0) ? i - 1 : 0] ? cell_q[(i > 0) ? i - 1 : 0] : g;
				end
			end else if (cmd.drain && (i < MAX_ITEMS - 1)) begin
				cell_q[i] <= cell_q[(i < MAX_ITEMS - 1) ? i + 1 : i];
			end
		end
	end

	// Positions of the grades that make up each median. For an odd span both
	// positions are the middle one, which doubles it.
	always_comb begin
		half = count_q >> 1;
		h2   = half >> 1;
		lo3  = count_q - half;
		b2   = half;
		a2   = count_q[0] ? half : half - cnt_t'(1);
		if (half == '0) begin
			a1 = a2;
			b1 = b2;
			a3 = a2;
			b3 = b2;
		end else begin
			b1 = h2;
			a1 = half[0] ? h2 : h2 - cnt_t'(1);
			b3 = lo3 + h2;
			a3 = half[0] ? b3 : b3 - cnt_t'(1);
		end
	end

	assign stat.drain_end = (k_q == count_q - cnt_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			k_q     <= '0;
		end else begin
			if (cmd.accept) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + cnt_t'(1);
				end
			end
			if (cmd.setup) begin
				k_q <= '0;
			end else if (cmd.drain) begin
				k_q <= k_q + cnt_t'(1);
			end
			if (cmd.load_out) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			a1_q <= a1;
			b1_q <= b1;
			a2_q <= a2;
			b2_q <= b2;
			a3_q <= a3;
			b3_q <= b3;
			q1_q <= '0;
			q2_q <= '0;
			q3_q <= '0;
		end else if (cmd.drain) begin
			q1_q <= q1_q + ((k_q == a1_q) ? head : '0) + ((k_q == b1_q) ? head : '0);
			q2_q <= q2_q + ((k_q == a2_q) ? head : '0) + ((k_q == b2_q) ? head : '0);
			q3_q <= q3_q + ((k_q == a3_q) ? head : '0) + ((k_q == b3_q) ? head : '0);
		end
		if (cmd.load_out) begin
			out_q.lower_quartile_x2 <= QUART_W'(q1_q);
			out_q.median_x2         <= QUART_W'(q2_q);
			out_q.upper_quartile_x2 <= QUART_W'(q3_q);
			out_q.item_count        <= ITEM_COUNT_W'(count_q);
			out_q.status            <= ovf_q;
		end
	end

	assign out_item = out_q;

endmodule

>>> verif/tb_sorted_quartile_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_quartile_engine_top
// Streams grade sets into the quartile engine with random gaps on both sides
// and checks every result against a sorted-set predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_sorted_quartile_engine_top;
	import sqe_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 2 * MAX_ITEMS + 8;
	localparam int RANDOM_ITEMS = 450;
	localparam int MAX_GAP      = 11;

	typedef struct {
		in_item_t    item;
		int unsigned gap;
	} grade_req_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	grade_req_t grade_feed[$];
	out_item_t  quartile_due[$];

	// Predictor state: the grades of the open set in ascending order.
	grade_t     roster[MAX_ITEMS];
	int         roster_len;
	bit         roster_dropped;

	bit         in_took;
	bit         out_took;
	bit         feed_calm;
	bit         drain_calm;
	int unsigned in_wait;
	int unsigned out_wait;
	int         idle_cycles;
	int         mismatches;
	int         random_fed;

	sorted_quartile_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [QUART_W-1:0] twice_median(int lo, int n);
		int mid;
		mid = lo + n / 2;
		if (n == 0 || mid >= MAX_ITEMS)
			return '0;
		if (n % 2 != 0)
			return {roster[mid], 1'b0};
		return QUART_W'(roster[mid - 1]) + QUART_W'(roster[mid]);
	endfunction

	task automatic absorb_grade(input in_item_t req);
		int pos;
		int half;
		out_item_t res;
		if (roster_len >= MAX_ITEMS) begin
			roster_dropped = 1'b1;
		end else begin
			// Equal grades stay in arrival order: shift only strictly larger ones.
			pos = roster_len;
			while (pos > 0 && roster[pos - 1] > req.grade) begin
				roster[pos] = roster[pos - 1];
				pos--;
			end
			roster[pos] = req.grade;
			roster_len++;
		end
		if (req.last) begin
			half = roster_len / 2;
			res.median_x2 = twice_median(0, roster_len);
			if (half == 0) begin
				res.lower_quartile_x2 = res.median_x2;
				res.upper_quartile_x2 = res.median_x2;
			end else begin
				res.lower_quartile_x2 = twice_median(0, half);
				res.upper_quartile_x2 = twice_median(roster_len - half, half);
			end
			res.item_count = ITEM_COUNT_W'(roster_len);
			res.status = roster_dropped;
			quartile_due.push_back(res);
			roster_len = 0;
			roster_dropped = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_grade(input int unsigned grade, input bit last);
		grade_req_t req;
		if ($urandom_range(0, 19) == 0)
			feed_calm = !feed_calm;
		req.item.grade = GRADE_W'(grade);
		req.item.last = last;
		req.gap = feed_calm ? 0 : $urandom_range(0, MAX_GAP);
		grade_feed.push_back(req);
	endtask

	task automatic queue_set(input int n);
		int style;
		int unsigned g;
		style = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			case (style)
				0: g = $urandom_range(0, 255);
				1: g = $urandom_range(0, 3);
				2: g = $urandom_range(252, 255);
				default: g = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255)
					: $urandom_range(120, 135);
			endcase
			queue_grade(g, i == n - 1);
		end
	endtask

	// Sample both channels at the rising edge; the drivers act on the flags
	// at the following falling edge.
	always @(posedge clk) begin : monitor
		out_item_t want;
		in_took = arst_n && in_valid && in_ready;
		out_took = arst_n && out_valid && out_ready;
		if (in_took)
			absorb_grade(in_item);
		if (out_took) begin
			if (quartile_due.size() == 0) begin
				$error("result with no request pending: q1 %0d q2 %0d q3 %0d",
					out_item.lower_quartile_x2, out_item.median_x2,
					out_item.upper_quartile_x2);
				mismatches++;
			end else begin
				want = quartile_due.pop_front();
				check_field("lower_quartile_x2", want.lower_quartile_x2,
					out_item.lower_quartile_x2);
				check_field("median_x2", want.median_x2, out_item.median_x2);
				check_field("upper_quartile_x2", want.upper_quartile_x2,
					out_item.upper_quartile_x2);
				check_field("item_count", want.item_count, out_item.item_count);
				check_field("status", want.status, out_item.status);
			end
		end
		if (!arst_n || in_took || out_took)
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	always @(negedge clk) begin : grade_driver
		logic     v;
		in_item_t d;
		grade_req_t req;
		v = in_valid;
		d = in_item;
		if (v && in_took)
			v = 1'b0;
		if (!v && arst_n && grade_feed.size() > 0) begin
			if (in_wait < grade_feed[0].gap) begin
				in_wait++;
			end else begin
				req = grade_feed.pop_front();
				d = req.item;
				v = 1'b1;
				in_wait = 0;
			end
		end
		in_valid <= v;
		in_item <= d;
	end

	always @(negedge clk) begin : result_sink
		logic r;
		r = out_ready;
		if (out_took) begin
			if ($urandom_range(0, 7) == 0)
				drain_calm = !drain_calm;
			out_wait = drain_calm ? 0 : $urandom_range(0, MAX_GAP);
			r = 1'b0;
		end
		if (!r && arst_n) begin
			if (out_wait > 0)
				out_wait--;
			else
				r = 1'b1;
		end
		out_ready <= r;
	end

	initial begin : stimulus
		int sets;
		int n;
		bit timed_out;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		roster_len = 0;
		roster_dropped = 1'b0;
		in_took = 1'b0;
		out_took = 1'b0;
		feed_calm = 1'b0;
		drain_calm = 1'b0;
		in_wait = 0;
		out_wait = 0;
		idle_cycles = 0;
		mismatches = 0;
		timed_out = 1'b0;

		// Single-grade sets at both extremes of the grade range.
		queue_grade(0, 1'b1);
		queue_grade(255, 1'b1);
		// Two grades: each half holds one of them.
		queue_grade(255, 1'b0);
		queue_grade(0, 1'b1);
		// Odd count arriving in descending order; the middle sits in neither half.
		queue_grade(200, 1'b0);
		queue_grade(10, 1'b0);
		queue_grade(3, 1'b1);
		// Even count; all three values have a half bit.
		queue_grade(4, 1'b0);
		queue_grade(3, 1'b0);
		queue_grade(2, 1'b0);
		queue_grade(1, 1'b1);
		// Equal grades only.
		for (int i = 0; i < 5; i++)
			queue_grade(7, i == 4);
		// Duplicates around the midpoint mixed with both extremes.
		queue_grade(128, 1'b0);
		queue_grade(127, 1'b0);
		queue_grade(128, 1'b0);
		queue_grade(127, 1'b0);
		queue_grade(255, 1'b0);
		queue_grade(0, 1'b1);

		// Mostly small sets; a full store, an overflow on the closing grade,
		// and an overflow followed by more dropped grades are placed among them.
		sets = 0;
		random_fed = 0;
		while (random_fed < RANDOM_ITEMS) begin
			case (sets)
				4: n = MAX_ITEMS;
				11: n = MAX_ITEMS + 1;
				19: n = $urandom_range(MAX_ITEMS + 2, MAX_ITEMS + 8);
				default: n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 12);
			endcase
			queue_set(n);
			random_fed += n;
			sets++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!timed_out && (grade_feed.size() > 0 || in_valid || quartile_due.size() > 0)) begin
			@(posedge clk);
			if (idle_cycles >= STALL_LIMIT)
				timed_out = 1'b1;
		end

		if (timed_out) begin
			$display("FAIL sorted_quartile_engine_top");
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (mismatches == 0 && quartile_due.size() == 0)
				$display("PASS sorted_quartile_engine_top");
			else
				$display("FAIL sorted_quartile_engine_top");
		end
		$finish;
	end

endmodule

>>> files.f
src/sqe_pkg.sv
src/sqe_ctrl.sv
src/sqe_dp.sv
src/sorted_quartile_engine_top.sv
verif/tb_sorted_quartile_engine_top.sv
